### rtl/core/vfi_pkg.sv
// Shared types and constants of the volume flow indicator.
`default_nettype none
package vfi_pkg;
	localparam int unsigned MAX_WINDOW_DEF = 256;
	// Wide enough for a window length up to 4096.
	localparam int unsigned PERIOD_W = 13;
	localparam int unsigned ADDR_W = 3;
	localparam logic REG_WINDOW_LENGTH = 1'b0;
	localparam logic [8:0] WINDOW_LENGTH_RESET = 9'd130;
	// ln(2) in Q0.32.
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic [31:0] Q824_MAX = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [33:0]          price_sum;
		logic [39:0]          volume;
		logic [31:0]          prior;
		logic [PERIOD_W-1:0]  period;
		logic                 has_result;
	} vfi_item_t;

	typedef struct packed {
		logic [31:0] typical;
		logic [31:0] log_typical;
		logic [39:0] volume;
	} vfi_entry_t;

	typedef enum logic [1:0] {
		LN_IDLE,
		LN_SQUARE,
		LN_SCALE,
		LN_ROUND
	} vfi_ln_state_t;

	typedef enum logic [4:0] {
		B_IDLE,
		B_DIV3,
		B_WAIT3,
		B_LNT,
		B_WAITLNT,
		B_WRITE,
		B_P1_RD,
		B_P1_SUB,
		B_P1_SQ,
		B_MSQ,
		B_WAITMSQ,
		B_SQRT,
		B_WAITSQRT,
		B_MULC,
		B_DIVC,
		B_WAITC,
		B_MVOL,
		B_WAITMV,
		B_P2_RD,
		B_P2_CMP,
		B_P2_DIV,
		B_P2_WDIV,
		B_P2_LN,
		B_P2_WLN,
		B_P2_NEXT,
		B_OUT
	} vfi_back_state_t;
endpackage
`default_nettype wire

### rtl/core/vfi_front.sv
// Front end: accepts bars, sums the prices and decides whether a result is due.
`default_nettype none
module vfi_front import vfi_pkg::*; #(
	parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] high_price,
	input  wire logic [31:0] low_price,
	input  wire logic [31:0] close_price,
	input  wire logic [39:0] bar_volume,
	input  wire logic [8:0]  window_length,
	input  wire logic        queue_full,
	output logic             push,
	output vfi_item_t        item
);
	localparam logic [PERIOD_W-1:0] MAXW = PERIOD_W'(MAX_WINDOW);

	logic [31:0]         bars_seen_q;
	logic [PERIOD_W-1:0] wl_ext;
	logic [PERIOD_W-1:0] period;

	assign wl_ext = PERIOD_W'(window_length);
	assign period = (window_length == 9'd0) ? PERIOD_W'(1) :
		((wl_ext > MAXW) ? MAXW : wl_ext);

	assign in_stall = queue_full;
	assign push = in_valid & ~queue_full;

	assign item.price_sum = {2'b00, high_price} + {2'b00, low_price} + {2'b00, close_price};
	assign item.volume = bar_volume;
	assign item.prior = bars_seen_q;
	assign item.period = period;
	// A result needs at least as many bars before this one as there are changes in the window.
	assign item.has_result = (bars_seen_q >= 32'(period));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bars_seen_q <= 32'd0;
		end else if (push && bars_seen_q != 32'hFFFF_FFFF) begin
			bars_seen_q <= bars_seen_q + 32'd1;
		end
	end
endmodule
`default_nettype wire

### rtl/core/vfi_queue.sv
// Two-entry queue between the front end and the back end.
`default_nettype none
module vfi_queue import vfi_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  vfi_item_t      push_item,
	input  wire logic      pop,
	output vfi_item_t      head,
	output logic           full,
	output logic           empty
);
	vfi_item_t  entries_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head = entries_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wp_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

### rtl/core/vfi_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module vfi_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [63:0] divisor,
	output logic             done,
	output logic [63:0]      quotient
);
	logic [64:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] trial;
	logic        fits;

	assign trial = {rem_q[63:0], quo_q[63]};
	assign fits = (trial >= {1'b0, dsr_q});
	assign done = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 65'd0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dsr_q}) : trial;
			quo_q <= {quo_q[62:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

### rtl/core/vfi_ln.sv
// Shared natural logarithm unit in Q8.24, one squaring step per cycle.
`default_nettype none
module vfi_ln import vfi_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] value,
	input  wire logic        frac_in,
	output logic             done,
	output logic [31:0]      result
);
	vfi_ln_state_t state_q;
	vfi_ln_state_t state_d;
	logic [31:0]   v1;
	logic [4:0]    p_c;
	logic [31:0]   m_q;
	logic [23:0]   frac_q;
	logic [4:0]    p_q;
	logic          fb_q;
	logic [4:0]    cnt_q;
	logic [63:0]   sq;
	logic [32:0]   sq_top;
	logic [4:0]    pf;
	logic [28:0]   l2;
	logic [60:0]   prod_q;
	logic [61:0]   rounded;
	logic          done_q;
	logic [31:0]   result_q;
	logic          step;

	assign v1 = (value == 32'd0) ? 32'd1 : value;

	always_comb begin
		p_c = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (v1[i]) begin
				p_c = 5'(i);
			end
		end
	end

	assign sq = 64'(m_q) * 64'(m_q);
	assign sq_top = sq[63:31];
	assign pf = p_q - (fb_q ? 5'd24 : 5'd0);
	// Below the fraction point the logarithm of a value under one clamps to zero.
	assign l2 = ((fb_q && p_q < 5'd24) ? 29'd0 : {pf, frac_q});
	assign rounded = {1'b0, prod_q} + 62'h8000_0000;
	assign done = done_q;
	assign result = result_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			LN_IDLE: begin
				if (start) begin
					state_d = LN_SQUARE;
				end
			end
			LN_SQUARE: begin
				if (cnt_q == 5'd23) begin
					state_d = LN_SCALE;
				end
			end
			LN_SCALE: state_d = LN_ROUND;
			LN_ROUND: state_d = LN_IDLE;
			default: state_d = LN_IDLE;
		endcase
	end

	always_comb begin
		step = 1'b0;
		case (state_q)
			LN_SQUARE: step = 1'b1;
			default: step = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == LN_IDLE && start) begin
			m_q <= 32'(v1 << (5'd31 - p_c));
			frac_q <= 24'd0;
			p_q <= p_c;
			fb_q <= frac_in;
			cnt_q <= 5'd0;
		end else if (step) begin
			m_q <= sq_top[32] ? sq_top[32:1] : sq_top[31:0];
			frac_q <= {frac_q[22:0], sq_top[32]};
			cnt_q <= cnt_q + 5'd1;
		end
		if (state_q == LN_SCALE) begin
			prod_q <= 61'(l2) * 61'(LN2_Q32);
		end
		if (state_q == LN_ROUND) begin
			result_q <= {2'b00, rounded[61:32]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LN_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == LN_ROUND);
		end
	end
endmodule
`default_nettype wire

### rtl/core/vfi_isqrt.sv
// Integer square root, two radicand bits per cycle.
`default_nettype none
module vfi_isqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic             done,
	output logic [31:0]      root
);
	logic [63:0] x_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;
	assign done = done_q;
	assign root = res_q[31:0];

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= radicand;
			res_q <= 64'd0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (x_q >= trial) begin
				x_q <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

### rtl/core/vfi_back.sv
// Back end: bar ring memory, the two window passes and the result register.
`default_nettype none
module vfi_back import vfi_pkg::*; #(
	parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        queue_empty,
	input  vfi_item_t        head,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      flow_value,
	output logic [31:0]      bar_index
);
	localparam int unsigned DEPTH = MAX_WINDOW + 1;
	localparam int unsigned SW = $clog2(DEPTH);
	localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_WINDOW);
	// ceil(2^22 / 3) and ceil(2^22 / 5): exact quotients for a 19-bit digit numerator.
	localparam logic [20:0] RECIP3 = 21'd1398102;
	localparam logic [20:0] RECIP5 = 21'd838861;

	vfi_back_state_t state_q;
	vfi_back_state_t state_d;

	vfi_entry_t mem [DEPTH];
	vfi_entry_t rdata_q;

	vfi_item_t           item_q;
	logic [SW-1:0]       wslot_q;
	logic [SW-1:0]       newest_q;
	logic [SW-1:0]       rd_slot_q;
	logic [PERIOD_W-1:0] j_q;
	logic [31:0]         t_q;
	logic [31:0]         lnt_q;
	logic [31:0]         prev_ln_q;
	logic [31:0]         prev_t_q;
	logic [39:0]         prev_vol_q;
	logic [31:0]         ad_q;
	logic [63:0]         sq_sum_q;
	logic [63:0]         vol_sum_q;
	logic [30:0]         mean_sq_q;
	logic [31:0]         rms_q;
	logic [63:0]         prod_q;
	logic [63:0]         cutoff_q;
	logic [39:0]         mean_vol_q;
	logic                up_q;
	logic [31:0]         ratio_q;
	logic signed [39:0]  flow_q;
	logic                out_valid_q;
	logic [31:0]         flow_value_q;
	logic [31:0]         bar_index_q;
	logic [63:0]         cd_x_q;
	logic [63:0]         cd_quo_q;
	logic [2:0]          cd_rem_q;
	logic [1:0]          cd_cnt_q;
	logic                cd_five_q;

	logic        rd_en;
	logic        mem_we;
	logic        div_start;
	logic [63:0] div_a;
	logic [63:0] div_b;
	logic        div_done;
	logic [63:0] div_q;
	logic        ln_start;
	logic [31:0] ln_value;
	logic        ln_frac;
	logic        ln_done;
	logic [31:0] ln_result;
	logic        sqrt_start;
	logic        sqrt_done;
	logic [31:0] sqrt_root;
	logic        out_load;
	logic        cd_load;
	logic        cd_five;
	logic [63:0] cd_in;

	logic                last_entry;
	logic [SW-1:0]       slot_dec;
	logic [SW-1:0]       slot_inc;
	logic signed [32:0]  ln_diff;
	logic [63:0]         sq_full;
	logic signed [32:0]  tdiff;
	logic signed [59:0]  scaled;
	logic signed [59:0]  cut;
	logic                up_c;
	logic                down_c;
	logic [39:0]         flow_abs;
	logic [40:0]         flow_rnd;
	logic [32:0]         mag;
	logic [32:0]         mag_neg;
	logic [31:0]         out_word;
	logic [18:0]         cd_num;
	logic [20:0]         cd_recip;
	logic [39:0]         cd_prod;
	logic [15:0]         cd_digit;
	logic [18:0]         cd_back;
	logic [2:0]          cd_rem;
	logic                cd_last;
	logic [63:0]         cd_result;

	assign last_entry = (j_q == item_q.period);
	assign slot_dec = (rd_slot_q == '0) ? LAST_SLOT : rd_slot_q - SW'(1);
	assign slot_inc = (wslot_q == LAST_SLOT) ? '0 : wslot_q + SW'(1);

	assign ln_diff = $signed({1'b0, prev_ln_q}) - $signed({1'b0, rdata_q.log_typical});
	assign sq_full = 64'(ad_q) * 64'(ad_q);

	assign tdiff = $signed({1'b0, prev_t_q}) - $signed({1'b0, rdata_q.typical});
	assign scaled = $signed({{3{tdiff[32]}}, tdiff, 24'd0});
	assign cut = $signed({1'b0, cutoff_q[58:0]});
	assign up_c = (scaled > cut);
	assign down_c = (scaled < -cut);

	assign flow_abs = flow_q[39] ? 40'(-flow_q) : 40'(flow_q);
	assign flow_rnd = {1'b0, flow_abs} + 41'd128;
	assign mag = flow_rnd[40:8];
	assign mag_neg = (mag > 33'h0_8000_0000) ? 33'h0_8000_0000 : mag;
	assign out_word = flow_q[39] ? (32'd0 - mag_neg[31:0]) :
		((mag > 33'h0_7FFF_FFFF) ? Q824_MAX : mag[31:0]);

	// Division by three or five, one 16-bit quotient digit per cycle.
	assign cd_num = {cd_rem_q, cd_x_q[63:48]};
	assign cd_recip = cd_five_q ? RECIP5 : RECIP3;
	assign cd_prod = 40'(cd_num) * 40'(cd_recip);
	assign cd_digit = cd_prod[37:22];
	assign cd_back = 19'(cd_digit) * (cd_five_q ? 19'd5 : 19'd3);
	assign cd_rem = 3'(cd_num - cd_back);
	assign cd_last = (cd_cnt_q == 2'd3);
	assign cd_result = {cd_quo_q[47:0], cd_digit};

	vfi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_q)
	);

	vfi_ln u_ln (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ln_start),
		.value   (ln_value),
		.frac_in (ln_frac),
		.done    (ln_done),
		.result  (ln_result)
	);

	vfi_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand ({9'd0, mean_sq_q, 24'd0}),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!queue_empty) begin
					state_d = B_DIV3;
				end
			end
			B_DIV3: state_d = B_WAIT3;
			B_WAIT3: begin
				if (cd_last) begin
					state_d = B_LNT;
				end
			end
			B_LNT: state_d = B_WAITLNT;
			B_WAITLNT: begin
				if (ln_done) begin
					state_d = B_WRITE;
				end
			end
			B_WRITE: state_d = item_q.has_result ? B_P1_RD : B_IDLE;
			B_P1_RD: state_d = B_P1_SUB;
			B_P1_SUB: state_d = B_P1_SQ;
			B_P1_SQ: state_d = last_entry ? B_MSQ : B_P1_RD;
			B_MSQ: state_d = B_WAITMSQ;
			B_WAITMSQ: begin
				if (div_done) begin
					state_d = B_SQRT;
				end
			end
			B_SQRT: state_d = B_WAITSQRT;
			B_WAITSQRT: begin
				if (sqrt_done) begin
					state_d = B_MULC;
				end
			end
			B_MULC: state_d = B_DIVC;
			B_DIVC: state_d = B_WAITC;
			B_WAITC: begin
				if (cd_last) begin
					state_d = B_MVOL;
				end
			end
			B_MVOL: state_d = B_WAITMV;
			B_WAITMV: begin
				if (div_done) begin
					state_d = B_P2_RD;
				end
			end
			B_P2_RD: state_d = B_P2_CMP;
			B_P2_CMP: begin
				if (j_q != '0 && (up_c || down_c) && mean_vol_q != 40'd0) begin
					state_d = B_P2_DIV;
				end else begin
					state_d = B_P2_NEXT;
				end
			end
			B_P2_DIV: state_d = B_P2_WDIV;
			B_P2_WDIV: begin
				if (div_done) begin
					state_d = B_P2_LN;
				end
			end
			B_P2_LN: state_d = B_P2_WLN;
			B_P2_WLN: begin
				if (ln_done) begin
					state_d = B_P2_NEXT;
				end
			end
			B_P2_NEXT: state_d = last_entry ? B_OUT : B_P2_RD;
			B_OUT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		rd_en = 1'b0;
		mem_we = 1'b0;
		div_start = 1'b0;
		div_a = 64'd0;
		div_b = 64'd1;
		ln_start = 1'b0;
		ln_value = t_q;
		ln_frac = 1'b0;
		sqrt_start = 1'b0;
		out_load = 1'b0;
		cd_load = 1'b0;
		cd_five = 1'b0;
		cd_in = 64'd0;
		case (state_q)
			B_IDLE: pop = ~queue_empty;
			B_DIV3: begin
				cd_load = 1'b1;
				cd_in = 64'(item_q.price_sum);
			end
			B_LNT: ln_start = 1'b1;
			B_WRITE: mem_we = 1'b1;
			B_P1_RD: rd_en = 1'b1;
			B_MSQ: begin
				div_start = 1'b1;
				div_a = sq_sum_q;
				div_b = 64'(item_q.period);
			end
			B_SQRT: sqrt_start = 1'b1;
			B_DIVC: begin
				cd_load = 1'b1;
				cd_five = 1'b1;
				cd_in = prod_q;
			end
			B_MVOL: begin
				div_start = 1'b1;
				div_a = vol_sum_q;
				div_b = 64'(item_q.period);
			end
			B_P2_RD: rd_en = 1'b1;
			B_P2_DIV: begin
				div_start = 1'b1;
				div_a = {prev_vol_q, 24'd0};
				div_b = 64'(mean_vol_q);
			end
			B_P2_LN: begin
				ln_start = 1'b1;
				ln_value = ratio_q + 32'h0100_0000;
				ln_frac = 1'b1;
			end
			B_OUT: out_load = ~out_valid_q | ~out_stall;
			default: pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wslot_q] <= '{typical: t_q, log_typical: lnt_q, volume: item_q.volume};
		end
		if (rd_en) begin
			rdata_q <= mem[rd_slot_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cd_load) begin
			cd_x_q <= cd_in;
			cd_quo_q <= 64'd0;
			cd_rem_q <= 3'd0;
			cd_cnt_q <= 2'd0;
			cd_five_q <= cd_five;
		end else begin
			cd_x_q <= {cd_x_q[47:0], 16'd0};
			cd_quo_q <= cd_result;
			cd_rem_q <= cd_rem;
			cd_cnt_q <= cd_cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
		if (state_q == B_WAIT3 && cd_last) begin
			t_q <= (cd_result[31:0] == 32'd0) ? 32'd1 : cd_result[31:0];
		end
		if (state_q == B_WAITLNT && ln_done) begin
			lnt_q <= ln_result;
		end
		case (state_q)
			B_WRITE: begin
				newest_q <= wslot_q;
				rd_slot_q <= wslot_q;
				j_q <= '0;
				sq_sum_q <= 64'd0;
				vol_sum_q <= 64'd0;
			end
			B_P1_SUB: begin
				ad_q <= ln_diff[32] ? 32'(-ln_diff) : ln_diff[31:0];
				if (j_q != '0) begin
					vol_sum_q <= vol_sum_q + 64'(prev_vol_q);
				end
			end
			B_P1_SQ: begin
				if (j_q != '0) begin
					sq_sum_q <= sq_sum_q + (sq_full >> 24);
				end
				prev_ln_q <= rdata_q.log_typical;
				prev_vol_q <= rdata_q.volume;
				prev_t_q <= rdata_q.typical;
				j_q <= j_q + PERIOD_W'(1);
				rd_slot_q <= slot_dec;
			end
			B_WAITMSQ: begin
				if (div_done) begin
					mean_sq_q <= (div_q > 64'(Q824_MAX)) ? Q824_MAX[30:0] : div_q[30:0];
				end
			end
			B_WAITSQRT: begin
				if (sqrt_done) begin
					rms_q <= sqrt_root;
				end
			end
			B_MULC: prod_q <= 64'(rms_q) * 64'(t_q);
			B_WAITC: begin
				if (cd_last) begin
					cutoff_q <= cd_result;
				end
			end
			B_WAITMV: begin
				if (div_done) begin
					mean_vol_q <= div_q[39:0];
					rd_slot_q <= newest_q;
					j_q <= '0;
					flow_q <= 40'sd0;
				end
			end
			B_P2_CMP: up_q <= up_c;
			B_P2_WDIV: begin
				if (div_done) begin
					// A ratio of 128 or more saturates to the Q8.24 maximum.
					ratio_q <= (div_q[63:31] != 33'd0) ? Q824_MAX : div_q[31:0];
				end
			end
			B_P2_WLN: begin
				if (ln_done) begin
					flow_q <= up_q ? flow_q + $signed({8'd0, ln_result}) :
						flow_q - $signed({8'd0, ln_result});
				end
			end
			B_P2_NEXT: begin
				prev_vol_q <= rdata_q.volume;
				prev_t_q <= rdata_q.typical;
				prev_ln_q <= rdata_q.log_typical;
				j_q <= j_q + PERIOD_W'(1);
				rd_slot_q <= slot_dec;
			end
			default: up_q <= up_q;
		endcase
		if (out_load) begin
			flow_value_q <= out_word;
			bar_index_q <= item_q.prior;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			wslot_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mem_we) begin
				wslot_q <= slot_inc;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign flow_value = flow_value_q;
	assign bar_index = bar_index_q;
endmodule
`default_nettype wire

### rtl/core/volume_flow_indicator_top.sv
// Top level of the volume flow indicator: register port, front end, queue and back end.
`default_nettype none
// Each bar is accepted into a two-entry queue by the front end, which sums the prices and
// notes whether the bar completes a window. The back end handles one bar at a time: it
// divides the price sum by three, takes its logarithm and stores the bar in the ring
// memory; a bar that produces a result then runs the first pass over the window, the
// mean, root and cutoff arithmetic, the second pass and, for each price change beyond the
// cutoff, a division and a logarithm. The serial divider serves the divisions by the window
// length and by the mean volume, and a separate unit divides by three and by five. A
// finished result waits in the output register while the next bar is taken. The ring
// memory needs no clearing after reset.
module volume_flow_indicator_top import vfi_pkg::*; #(
	parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [31:0]       high_price,
	input  wire logic [31:0]       low_price,
	input  wire logic [31:0]       close_price,
	input  wire logic [39:0]       bar_volume,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic signed [31:0]     flow_value,
	output logic [31:0]            bar_index
);
	logic [8:0] window_length_q;
	logic       push;
	logic       pop;
	logic       queue_full;
	logic       queue_empty;
	vfi_item_t  push_item;
	vfi_item_t  head;
	logic [31:0] flow_word;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? {23'd0, window_length_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WINDOW_LENGTH_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_WINDOW_LENGTH) begin
			window_length_q <= pwdata[8:0];
		end
	end

	vfi_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.high_price    (high_price),
		.low_price     (low_price),
		.close_price   (close_price),
		.bar_volume    (bar_volume),
		.window_length (window_length_q),
		.queue_full    (queue_full),
		.push          (push),
		.item          (push_item)
	);

	vfi_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	vfi_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.flow_value  (flow_word),
		.bar_index   (bar_index)
	);

	assign flow_value = $signed(flow_word);
endmodule
`default_nettype wire
